@@ sv/joint_pid_force_actuator_assert.svh @@
// ---------------------------------------------------------------------------
// Joint actuator assertion macros
// Shared property forms for the concurrent checks of the joint actuator.
// ---------------------------------------------------------------------------
`ifndef JOINT_PID_FORCE_ACTUATOR_ASSERT_SVH
`define JOINT_PID_FORCE_ACTUATOR_ASSERT_SVH

// Condition implies property in the same cycle
`define JPFA_ASSERT_IMPLY(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (prop)) \
        else $error("joint actuator check failed");

// Condition implies property in the following cycle
`define JPFA_ASSERT_NEXT(label, ck, rn, cond, prop) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
        else $error("joint actuator check failed");

`endif

@@ sv/jpfa_pkg.sv @@
// ---------------------------------------------------------------------------
// Joint actuator package
// Types, register codes and fixed-point constants shared by the actuator.
// ---------------------------------------------------------------------------
package jpfa_pkg;

    // Number of axis slots on the ports
    localparam int NAX = 3;

    // Fixed-point format of forces, positions and velocities
    localparam int FRAC_BITS = 16;

    // Configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 63;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DRIVE_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_P       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_D       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAIN_I_DT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_MIN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FORCE_MAX    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_POS_TOL_SQ   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_VEL_TOL_SQ   = 3'd7;

    // Command codes
    localparam logic CMD_SET_TARGET = 1'b0;
    localparam logic CMD_STEP       = 1'b1;

    // Control modes
    localparam logic MODE_FORCE = 1'b0;
    localparam logic MODE_PID   = 1'b1;

    typedef struct packed {
        logic               drive_mode;
        logic [23:0]        gain_p;
        logic [23:0]        gain_d;
        logic [23:0]        gain_i_dt;
        logic signed [31:0] force_min;
        logic signed [31:0] force_max;
        logic [62:0]        pos_tol_sq;
        logic [62:0]        vel_tol_sq;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        drive_mode:   MODE_PID,
        gain_p:       24'd0,
        gain_d:       24'd0,
        gain_i_dt:    24'd0,
        force_min:    -32'sd65536,
        force_max:    32'sd65536,
        pos_tol_sq:   63'd0,
        vel_tol_sq:   63'd0
    };

    // Per-item control handed to every axis lane
    typedef struct packed {
        logic fire;
        logic set_target;
        logic pid_step;
    } lane_ctl_t;

endpackage

@@ sv/jpfa_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// Joint actuator configuration registers
// Write-only register file for mode, gains, force limits and tolerances.
// ---------------------------------------------------------------------------
module jpfa_cfg_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [jpfa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [jpfa_pkg::CFG_DATA_W-1:0]       cfg_data,
    output jpfa_pkg::cfg_t                        cfg
);
    import jpfa_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write into the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DRIVE_MODE:   cfg_next.drive_mode   = cfg_data[0];
                CFG_GAIN_P:       cfg_next.gain_p       = cfg_data[23:0];
                CFG_GAIN_D:       cfg_next.gain_d       = cfg_data[23:0];
                CFG_GAIN_I_DT:    cfg_next.gain_i_dt    = cfg_data[23:0];
                CFG_FORCE_MIN:    cfg_next.force_min    = $signed(cfg_data[31:0]);
                CFG_FORCE_MAX:    cfg_next.force_max    = $signed(cfg_data[31:0]);
                CFG_POS_TOL_SQ:   cfg_next.pos_tol_sq   = cfg_data;
                CFG_VEL_TOL_SQ:   cfg_next.vel_tol_sq   = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/jpfa_axis_lane.sv @@
// ---------------------------------------------------------------------------
// Joint actuator axis lane
// Per-axis state, PID force law, direct force mapping and squared errors.
// ---------------------------------------------------------------------------
module jpfa_axis_lane
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  jpfa_pkg::cfg_t        cfg,
    input  jpfa_pkg::lane_ctl_t   ctl,
    input  logic signed [31:0]    target,
    input  logic signed [31:0]    pos,
    input  logic signed [31:0]    vel,
    output logic signed [31:0]    drive,
    output logic [63:0]           pos_sq,
    output logic [63:0]           vel_sq
);
    import jpfa_pkg::*;

    localparam int SH    = 24 - FRAC_BITS;
    localparam int MAP_W = FRAC_BITS + 36;

    localparam logic signed [31:0] I32_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] I32_MIN  = -32'sh8000_0000;
    localparam logic signed [47:0] I48_MAX  = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] I48_MIN  = -48'sh8000_0000_0000;
    localparam logic signed [31:0] ONE      = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] TERM_LIM = 64'sd1 <<< 60;
    localparam logic signed [63:0] TERM_BND = TERM_LIM >>> SH;

    // Axis state
    logic signed [31:0] target_reg,   target_next;
    logic signed [47:0] integral_reg, integral_next;
    logic signed [31:0] pos_err_reg,  pos_err_next;
    logic signed [31:0] vel_err_reg,  vel_err_next;

    // Error terms
    logic signed [32:0] pos_diff;
    logic signed [32:0] vel_neg;
    logic signed [31:0] pos_err;
    logic signed [31:0] vel_err;
    logic signed [48:0] int_sum;
    logic signed [47:0] int_new;

    // PID products
    logic signed [56:0] prod_p;
    logic signed [56:0] prod_d;
    logic signed [48:0] prod_hi;
    logic [47:0]        prod_lo;
    logic signed [63:0] hi_wide;
    logic signed [63:0] i_raw;
    logic signed [63:0] i_term;
    logic signed [63:0] pid_sum;
    logic signed [63:0] pid_hi_clamp;
    logic signed [63:0] pid_clamp;

    // Direct mapping
    logic signed [31:0]        u_sat;
    logic signed [31:0]        u_sum;
    logic [FRAC_BITS+1:0]      u_off;
    logic signed [32:0]        span;
    logic signed [MAP_W-1:0]   map_prod;
    logic signed [MAP_W-1:0]   map_sum;

    // Squared errors
    logic signed [31:0] pos_use;
    logic signed [31:0] vel_use;
    logic signed [63:0] pos_sq_s;
    logic signed [63:0] vel_sq_s;

    // Form saturated position and velocity errors
    always_comb
    begin
        pos_diff = {target_reg[31], target_reg} - {pos[31], pos};
        if (pos_diff[32] != pos_diff[31])
        begin
            pos_err = pos_diff[32] ? I32_MIN : I32_MAX;
        end
        else
        begin
            pos_err = pos_diff[31:0];
        end

        vel_neg = 33'sd0 - {vel[31], vel};
        if (vel_neg[32] != vel_neg[31])
        begin
            vel_err = vel_neg[32] ? I32_MIN : I32_MAX;
        end
        else
        begin
            vel_err = vel_neg[31:0];
        end
    end

    // Accumulate the integral with 48-bit saturation
    always_comb
    begin
        int_sum = {integral_reg[47], integral_reg} + {{17{pos_err[31]}}, pos_err};
        if (int_sum[48] != int_sum[47])
        begin
            int_new = int_sum[48] ? I48_MIN : I48_MAX;
        end
        else
        begin
            int_new = int_sum[47:0];
        end
    end

    // Integral term from two 24-bit partial products
    always_comb
    begin
        prod_hi = 49'($signed({1'b0, cfg.gain_i_dt})) * 49'($signed(int_new[47:24]));
        prod_lo = 48'(cfg.gain_i_dt) * 48'(int_new[23:0]);
        hi_wide = 64'(prod_hi);
        i_raw   = (hi_wide <<< SH) + $signed({16'b0, prod_lo >> FRAC_BITS});
        if (hi_wide > TERM_BND)
        begin
            i_term = TERM_LIM;
        end
        else if (hi_wide < -TERM_BND)
        begin
            i_term = -TERM_LIM;
        end
        else if (i_raw > TERM_LIM)
        begin
            i_term = TERM_LIM;
        end
        else if (i_raw < -TERM_LIM)
        begin
            i_term = -TERM_LIM;
        end
        else
        begin
            i_term = i_raw;
        end
    end

    // Sum the PID terms and clamp, upper limit first
    always_comb
    begin
        prod_p  = 57'($signed({1'b0, cfg.gain_p})) * 57'(pos_err);
        prod_d  = 57'($signed({1'b0, cfg.gain_d})) * 57'(vel_err);
        pid_sum = 64'(prod_p >>> FRAC_BITS) + 64'(prod_d >>> FRAC_BITS) + i_term;
        pid_hi_clamp = (pid_sum > 64'(cfg.force_max)) ? 64'(cfg.force_max) : pid_sum;
        pid_clamp    = (pid_hi_clamp < 64'(cfg.force_min)) ? 64'(cfg.force_min)
                                                           : pid_hi_clamp;
    end

    // Map the clamped target onto the force range
    always_comb
    begin
        if (target_reg > ONE)
        begin
            u_sat = ONE;
        end
        else if (target_reg < -ONE)
        begin
            u_sat = -ONE;
        end
        else
        begin
            u_sat = target_reg;
        end
        u_sum    = u_sat + ONE;
        u_off    = u_sum[FRAC_BITS+1:0];
        span     = {cfg.force_max[31], cfg.force_max} - {cfg.force_min[31], cfg.force_min};
        map_prod = MAP_W'($signed({1'b0, u_off})) * MAP_W'(span);
        map_sum  = (map_prod >>> (FRAC_BITS + 1)) + MAP_W'(cfg.force_min);
    end

    // Select the drive for this item
    always_comb
    begin
        priority if (ctl.set_target)
        begin
            drive = '0;
        end
        else if (ctl.pid_step)
        begin
            drive = pid_clamp[31:0];
        end
        else
        begin
            drive = map_sum[31:0];
        end
    end

    // Square the errors the item leaves behind
    always_comb
    begin
        pos_use  = ctl.pid_step ? pos_err : pos_err_reg;
        vel_use  = ctl.pid_step ? vel_err : vel_err_reg;
        pos_sq_s = 64'(pos_use) * 64'(pos_use);
        vel_sq_s = 64'(vel_use) * 64'(vel_use);
        pos_sq   = $unsigned(pos_sq_s);
        vel_sq   = $unsigned(vel_sq_s);
    end

    // Update axis state when the item leaves the input register
    always_comb
    begin
        target_next   = target_reg;
        integral_next = integral_reg;
        pos_err_next  = pos_err_reg;
        vel_err_next  = vel_err_reg;
        if (ctl.fire && ctl.set_target)
        begin
            target_next   = target;
            integral_next = '0;
        end
        else if (ctl.fire && ctl.pid_step)
        begin
            integral_next = int_new;
            pos_err_next  = pos_err;
            vel_err_next  = vel_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg   <= '0;
            integral_reg <= '0;
            pos_err_reg  <= '0;
            vel_err_reg  <= '0;
        end
        else
        begin
            target_reg   <= target_next;
            integral_reg <= integral_next;
            pos_err_reg  <= pos_err_next;
            vel_err_reg  <= vel_err_next;
        end
    end

endmodule

@@ sv/joint_pid_force_actuator.sv @@
// ---------------------------------------------------------------------------
// Joint PID force actuator
// Three-axis translational actuator: PID position control or direct force
// mapping, with force clamp and a squared-error completion flag.
// ---------------------------------------------------------------------------
//  channel   handshake                 payload
//  step      step_valid / step_stall   command, target_*, pos_*, vel_*
//  result    result_valid / result_stall  force_*, done_res
//  config    cfg_we                    cfg_index, cfg_data
//
//  One request per cycle sustained while results are not stalled; a request
//  is taken into the input register, its result is then loaded into the
//  result register, and the result can be taken from there.
//  The rate is set by the per-axis target, integral and error registers,
//  whose update loop passes through no further register.
//  Reset clears targets, integrals and stored errors and loads the register
//  defaults; no clearing pass is needed.
//  A stalled result holds the input register, which then stalls new requests.
// ---------------------------------------------------------------------------
`include "joint_pid_force_actuator_assert.svh"

module joint_pid_force_actuator
#(
    parameter int AXES = 3
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_we,
    input  logic [jpfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [jpfa_pkg::CFG_DATA_W-1:0]   cfg_data,
    // step requests
    input  logic                              step_valid,
    output logic                              step_stall,
    input  logic                              command,
    input  logic signed [31:0]                target_x,
    input  logic signed [31:0]                target_y,
    input  logic signed [31:0]                target_z,
    input  logic signed [31:0]                pos_x,
    input  logic signed [31:0]                pos_y,
    input  logic signed [31:0]                pos_z,
    input  logic signed [31:0]                vel_x,
    input  logic signed [31:0]                vel_y,
    input  logic signed [31:0]                vel_z,
    // results
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic signed [31:0]                force_x,
    output logic signed [31:0]                force_y,
    output logic signed [31:0]                force_z,
    output logic                              done_res
);
    import jpfa_pkg::*;

    cfg_t      cfg;
    lane_ctl_t lane_ctl;

    logic signed [31:0] target_in [NAX];
    logic signed [31:0] pos_in    [NAX];
    logic signed [31:0] vel_in    [NAX];

    // Input register
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_command_reg;
    logic signed [31:0] s1_target_reg [AXES];
    logic signed [31:0] s1_pos_reg    [AXES];
    logic signed [31:0] s1_vel_reg    [AXES];

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic signed [31:0] out_force_reg [NAX];
    logic               out_done_reg;

    logic               fire;
    logic               take;

    logic signed [31:0] lane_drive  [NAX];
    logic [63:0]        lane_pos_sq [NAX];
    logic [63:0]        lane_vel_sq [NAX];
    logic [63:0]        pos_norm;
    logic [63:0]        vel_norm;
    logic               done_next;

    assign target_in[0] = target_x;
    assign target_in[1] = target_y;
    assign target_in[2] = target_z;
    assign pos_in[0]    = pos_x;
    assign pos_in[1]    = pos_y;
    assign pos_in[2]    = pos_z;
    assign vel_in[0]    = vel_x;
    assign vel_in[1]    = vel_y;
    assign vel_in[2]    = vel_z;

    jpfa_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the held request whenever the result register is free
    assign fire       = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign take       = step_valid && !step_stall;
    assign step_stall = s1_valid_reg && !fire;

    always_comb
    begin
        lane_ctl.fire       = fire;
        lane_ctl.set_target = (s1_command_reg == CMD_SET_TARGET);
        lane_ctl.pid_step   = (s1_command_reg == CMD_STEP) && (cfg.drive_mode == MODE_PID);
    end

    // One lane per active axis; idle slots drive zero
    for (genvar i = 0; i < NAX; i++)
    begin : g_axis
        if (i < AXES)
        begin : g_on
            jpfa_axis_lane u_lane
            (
                .clk    (clk),
                .rst_n  (rst_n),
                .cfg    (cfg),
                .ctl    (lane_ctl),
                .target (s1_target_reg[i]),
                .pos    (s1_pos_reg[i]),
                .vel    (s1_vel_reg[i]),
                .drive  (lane_drive[i]),
                .pos_sq (lane_pos_sq[i]),
                .vel_sq (lane_vel_sq[i])
            );
        end
        else
        begin : g_off
            assign lane_drive[i]  = '0;
            assign lane_pos_sq[i] = '0;
            assign lane_vel_sq[i] = '0;
        end
    end

    // Sum the squared errors and compare against the tolerances
    always_comb
    begin
        pos_norm = '0;
        vel_norm = '0;
        for (int i = 0; i < NAX; i++)
        begin
            pos_norm = pos_norm + lane_pos_sq[i];
            vel_norm = vel_norm + lane_vel_sq[i];
        end
        done_next = (pos_norm < {1'b0, cfg.pos_tol_sq}) && (vel_norm < {1'b0, cfg.vel_tol_sq});
    end

    // Valid flags of both stages
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture a request into the input register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_command_reg <= command;
            for (int i = 0; i < AXES; i++)
            begin
                s1_target_reg[i] <= target_in[i];
                s1_pos_reg[i]    <= pos_in[i];
                s1_vel_reg[i]    <= vel_in[i];
            end
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < NAX; i++)
            begin
                out_force_reg[i] <= lane_drive[i];
            end
            out_done_reg <= done_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign force_x      = out_force_reg[0];
    assign force_y      = out_force_reg[1];
    assign force_z      = out_force_reg[2];
    assign done_res     = out_done_reg;

    // Checks
    `JPFA_ASSERT_NEXT(a_fire_gives_result, clk, rst_n, fire, result_valid)
    `JPFA_ASSERT_NEXT(a_set_target_zero_force, clk, rst_n, fire && lane_ctl.set_target, force_x == '0 && force_y == '0 && force_z == '0)
    `JPFA_ASSERT_NEXT(a_pid_force_floor, clk, rst_n, fire && lane_ctl.pid_step, force_x >= $past(cfg.force_min))

endmodule
